// ===== rtl/worst_fit_decreasing_packer_defines.svh =====
// assertion macros used by the top-level packer module
// no dependencies; included by files that carry assertions
`ifndef WORST_FIT_DECREASING_PACKER_DEFINES_SVH
`define WORST_FIT_DECREASING_PACKER_DEFINES_SVH

// checked property, held off while reset is high
`define WFD_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked property that also holds across reset
`define WFD_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/wfd_pkg.sv =====
// shared types and constants of the worst-fit-decreasing packer
// no dependencies; used by every module of the packer
package wfd_pkg;

   localparam int MAX_ITEMS_DEF = 16;
   localparam int MAX_BINS_DEF  = 8;
   localparam int IDENT_W       = 8;
   localparam int AMOUNT_W      = 16;
   localparam int KIND_W        = 2;

   typedef enum logic [KIND_W-1:0] {
      KIND_ITEM = 2'd0,
      KIND_BIN  = 2'd1,
      KIND_RUN  = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } state_type;

   // one stored item or bin: amount is the item size or the bin room
   typedef struct packed {
      logic                valid;
      logic [IDENT_W-1:0]  ident;
      logic [AMOUNT_W-1:0] amount;
   } entry_type;

   typedef struct packed {
      logic insert;
      logic pop;
   } item_ctl_type;

   typedef struct packed {
      logic insert;
      logic reinsert;
      logic clear;
   } bin_ctl_type;

endpackage

// ===== rtl/wfd_item_cell.sv =====
// one cell of the item chain, kept sorted by descending size
// depends on wfd_pkg
module wfd_item_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  wfd_pkg::item_ctl_type ctl,
   input  wfd_pkg::entry_type   new_entry,
   input  wfd_pkg::entry_type   prev_entry,
   input  logic                 prev_beats,
   input  wfd_pkg::entry_type   next_entry,
   output wfd_pkg::entry_type   entry,
   output logic                 beats
);

   wfd_pkg::entry_type entry_ff;
   wfd_pkg::entry_type entry_in;

   // equal sizes stay ahead of the newcomer
   assign beats = entry_ff.valid && (entry_ff.amount >= new_entry.amount);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.pop) begin
         entry_in = next_entry;
      end else if (ctl.insert && !beats) begin
         entry_in = prev_beats ? new_entry : prev_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff <= entry_in;
      end
   end

endmodule

// ===== rtl/wfd_bin_cell.sv =====
// one cell of the bin chain, sorted by room, ties by load order
// depends on wfd_pkg
module wfd_bin_cell #(
   parameter int IDX_W = 4,
   parameter bit HEAD  = 1'b0
) (
   input  logic                clock,
   input  logic                reset,
   input  wfd_pkg::bin_ctl_type ctl,
   input  wfd_pkg::entry_type  key_entry,
   input  logic [IDX_W-1:0]    key_idx,
   input  wfd_pkg::entry_type  prev_entry,
   input  logic [IDX_W-1:0]    prev_idx,
   input  logic                prev_beats,
   input  wfd_pkg::entry_type  next_entry,
   input  logic [IDX_W-1:0]    next_idx,
   input  logic                next_beats,
   output wfd_pkg::entry_type  entry,
   output logic [IDX_W-1:0]    idx,
   output logic                beats
);

   wfd_pkg::entry_type entry_ff;
   wfd_pkg::entry_type entry_in;
   logic [IDX_W-1:0]   idx_ff;
   logic [IDX_W-1:0]   idx_in;

   assign beats = entry_ff.valid &&
                  ((entry_ff.amount > key_entry.amount) ||
                   ((entry_ff.amount == key_entry.amount) && (idx_ff < key_idx)));
   assign entry = entry_ff;
   assign idx   = idx_ff;

   always_comb begin
      entry_in = entry_ff;
      idx_in   = idx_ff;
      if (ctl.clear) begin
         entry_in.valid = 1'b0;
      end else if (ctl.reinsert) begin
         // head leaves, cells that outrank the updated bin move up one
         if (next_beats) begin
            entry_in = next_entry;
            idx_in   = next_idx;
         end else if (HEAD || beats) begin
            entry_in = key_entry;
            idx_in   = key_idx;
         end
      end else if (ctl.insert && !beats) begin
         if (prev_beats) begin
            entry_in = key_entry;
            idx_in   = key_idx;
         end else begin
            entry_in = prev_entry;
            idx_in   = prev_idx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff <= entry_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

// ===== rtl/worst_fit_decreasing_packer.sv =====
// worst-fit-decreasing packer: item and bin loads are accepted while idle
// a run reports one item per cycle while the result register can take it, set by the
// item chain popping one entry and the bin chain re-sorting one bin a cycle
// input is stalled for the whole run; results come from the result register after the run state is entered
// synchronous reset empties both chains and returns to idle; no clearing pass
// depends on wfd_pkg, wfd_item_cell, wfd_bin_cell and the defines header
`include "worst_fit_decreasing_packer_defines.svh"

module worst_fit_decreasing_packer #(
   parameter int MAX_ITEMS = wfd_pkg::MAX_ITEMS_DEF,
   parameter int MAX_BINS  = wfd_pkg::MAX_BINS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // ident [7:0], amount [23:8]
   input  logic [1:0]  req_tuser,   // kind [1:0]
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // item_ident [7:0], bin_ident [15:8], room_left [31:16]
   output logic        rsp_tuser,   // placed [0]
   output logic        rsp_tlast
);

   localparam int IDX_W = $clog2(MAX_BINS + 1);

   // control
   wfd_pkg::state_type state_ff, state_in;
   logic [IDX_W-1:0]   bin_count_ff, bin_count_in;

   // chains
   wfd_pkg::entry_type item_q     [MAX_ITEMS];
   logic               item_beats [MAX_ITEMS];
   wfd_pkg::entry_type bin_q      [MAX_BINS];
   logic [IDX_W-1:0]   bin_idx    [MAX_BINS];
   logic               bin_beats  [MAX_BINS];
   logic [MAX_ITEMS-1:0] item_vld;

   wfd_pkg::item_ctl_type item_ctl;
   wfd_pkg::bin_ctl_type  bin_ctl;
   wfd_pkg::entry_type    item_new;
   wfd_pkg::entry_type    bin_key;
   logic [IDX_W-1:0]      bin_key_idx;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_data_ff,  rsp_data_in;
   logic        rsp_user_ff,  rsp_user_in;
   logic        rsp_last_ff,  rsp_last_in;

   wfd_pkg::kind_type     kind;
   logic                  req_xfer;
   logic                  step;
   logic                  fits;
   logic                  last_item;
   logic [15:0]           room_after;
   wfd_pkg::entry_type    item_second;
   wfd_pkg::entry_type    bin_second;

   assign kind       = wfd_pkg::kind_type'(req_tuser);
   assign req_tready = (state_ff == wfd_pkg::ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;

   // one placement per cycle when the result register can take it
   assign step = (state_ff == wfd_pkg::ST_RUN) && (!rsp_valid_ff || rsp_tready);

   // head of the item chain against head of the bin chain (most room)
   assign item_second = (MAX_ITEMS > 1) ? item_q[(MAX_ITEMS > 1) ? 1 : 0] : '0;
   assign bin_second  = (MAX_BINS > 1)  ? bin_q[(MAX_BINS > 1) ? 1 : 0]   : '0;
   assign last_item   = !item_second.valid;
   assign fits        = bin_q[0].valid && (bin_q[0].amount >= item_q[0].amount);
   assign room_after  = bin_q[0].amount - item_q[0].amount;

   assign item_new = '{valid: 1'b1, ident: req_tdata[7:0], amount: req_tdata[23:8]};

   always_comb begin
      item_ctl     = '0;
      bin_ctl      = '0;
      bin_key      = '{valid: 1'b1, ident: req_tdata[7:0], amount: req_tdata[23:8]};
      bin_key_idx  = bin_count_ff;
      state_in     = state_ff;
      bin_count_in = bin_count_ff;
      case (state_ff)
         wfd_pkg::ST_IDLE: begin
            if (req_xfer) begin
               case (kind)
                  wfd_pkg::KIND_ITEM: begin
                     // full chain drops the load
                     item_ctl.insert = !item_q[MAX_ITEMS-1].valid;
                  end
                  wfd_pkg::KIND_BIN: begin
                     if (!bin_q[MAX_BINS-1].valid) begin
                        bin_ctl.insert = 1'b1;
                        bin_count_in   = bin_count_ff + 1'b1;
                     end
                  end
                  wfd_pkg::KIND_RUN: begin
                     if (item_q[0].valid) begin
                        state_in = wfd_pkg::ST_RUN;
                     end else begin
                        // nothing to place: just forget the bins
                        bin_ctl.clear = 1'b1;
                        bin_count_in  = '0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         wfd_pkg::ST_RUN: begin
            if (step) begin
               item_ctl.pop     = 1'b1;
               bin_ctl.reinsert = fits;
               bin_key          = '{valid: 1'b1, ident: bin_q[0].ident, amount: room_after};
               bin_key_idx      = bin_idx[0];
               if (last_item) begin
                  bin_ctl.clear = 1'b1;
                  bin_count_in  = '0;
                  state_in      = wfd_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = wfd_pkg::ST_IDLE;
         end
      endcase
   end

   // item chain: sorted insert on load, pops from the head during a run
   for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_item
      wfd_pkg::entry_type prev_e;
      wfd_pkg::entry_type next_e;
      logic               prev_b;
      if (i == 0) begin : g_first
         assign prev_e = '0;
         assign prev_b = 1'b1;
      end else begin : g_mid
         assign prev_e = item_q[i-1];
         assign prev_b = item_beats[i-1];
      end
      if (i == MAX_ITEMS - 1) begin : g_end
         assign next_e = '0;
      end else begin : g_nxt
         assign next_e = item_q[i+1];
      end
      assign item_vld[i] = item_q[i].valid;
      wfd_item_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (item_ctl),
         .new_entry  (item_new),
         .prev_entry (prev_e),
         .prev_beats (prev_b),
         .next_entry (next_e),
         .entry      (item_q[i]),
         .beats      (item_beats[i])
      );
   end

   // bin chain: most room at the head, earliest loaded first on ties
   for (genvar j = 0; j < MAX_BINS; j++) begin : g_bin
      wfd_pkg::entry_type prev_e;
      wfd_pkg::entry_type next_e;
      logic [IDX_W-1:0]   prev_i;
      logic [IDX_W-1:0]   next_i;
      logic               prev_b;
      logic               next_b;
      if (j == 0) begin : g_first
         assign prev_e = '0;
         assign prev_i = '0;
         assign prev_b = 1'b1;
      end else begin : g_mid
         assign prev_e = bin_q[j-1];
         assign prev_i = bin_idx[j-1];
         assign prev_b = bin_beats[j-1];
      end
      if (j == MAX_BINS - 1) begin : g_end
         assign next_e = '0;
         assign next_i = '0;
         assign next_b = 1'b0;
      end else begin : g_nxt
         assign next_e = bin_q[j+1];
         assign next_i = bin_idx[j+1];
         assign next_b = bin_beats[j+1];
      end
      wfd_bin_cell #(
         .IDX_W (IDX_W),
         .HEAD  (j == 0)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (bin_ctl),
         .key_entry  (bin_key),
         .key_idx    (bin_key_idx),
         .prev_entry (prev_e),
         .prev_idx   (prev_i),
         .prev_beats (prev_b),
         .next_entry (next_e),
         .next_idx   (next_i),
         .next_beats (next_b),
         .entry      (bin_q[j]),
         .idx        (bin_idx[j]),
         .beats      (bin_beats[j])
      );
   end

   // result register, holds while the consumer stalls
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_last_in  = rsp_last_ff;
      if (step) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {fits ? room_after : 16'd0,
                         fits ? bin_q[0].ident : 8'd0,
                         item_q[0].ident};
         rsp_user_in  = fits;
         rsp_last_in  = last_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wfd_pkg::ST_IDLE;
         bin_count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bin_count_ff <= bin_count_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_data_ff  <= rsp_data_in;
         rsp_user_ff  <= rsp_user_in;
         rsp_last_ff  <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   // item chain fills from the head without holes
   `WFD_ASSERT(a_item_packed, ((item_vld >> 1) & ~item_vld) == '0, "item chain has a hole")
   // item chain stays in descending size order
   `WFD_ASSERT(a_item_sorted, (item_q[0].valid && item_second.valid) |-> (item_q[0].amount >= item_second.amount), "item chain out of order")
   // bin head always holds the most room
   `WFD_ASSERT(a_bin_sorted, (bin_q[0].valid && bin_second.valid) |-> (bin_q[0].amount >= bin_second.amount), "bin head is not the emptiest")
   // the final placement of a run empties the bins and frees the input
   `WFD_ASSERT(a_run_end, (step && last_item) |=> (!bin_q[0].valid && req_tready && bin_count_ff == '0), "run did not wind up")

endmodule
